/* sv/npcg_pkg.sv */
`timescale 1ns / 1ps

package npcg_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TINT = 2'd0;
  localparam logic [1:0] CFG_HUE  = 2'd1;
  localparam logic [1:0] CFG_GREY = 2'd2;

  localparam logic [7:0] TINT_RESET = 8'd128;
  localparam logic [7:0] HUE_RESET  = 8'd128;

  // angle bookkeeping in 1/64 degree
  localparam int ANGLE_FULL    = 23040;
  localparam int ANGLE_QUARTER = 5760;
  localparam int ANGLE_OFFSET  = 20608;
  localparam int ANGLE_THIRTY  = 1920;
  localparam int HUE_STEP      = 5;

  localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] RAD_PER_UNIT = PI_Q62 / 64'd11520;
  localparam logic [63:0] HALF_LSB_Q62 = 64'h0000_4000_0000_0000;

  typedef logic signed [16:0] trig_t;
  typedef logic [255:0][16:0] trig_tab_t;

  // stage 1 result: luma in hundredths, gated tint, rotated sin/cos in q1.15
  typedef struct packed {
    logic [6:0] luma;
    logic [7:0] tint;
    trig_t      sin_v;
    trig_t      cos_v;
  } phase_t;

  // channel levels scaled by 256*100 (red, blue) and 256*5300 (green)
  typedef struct packed {
    logic signed [16:0] m_red;
    logic signed [22:0] m_green;
    logic signed [16:0] m_blue;
  } level_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // (a*b) >> 62 out of 32-bit partial products
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, ll, lh, hl, hh, mid, hi, lo;
    ah  = {32'd0, a[63:32]};
    al  = {32'd0, a[31:0]};
    bh  = {32'd0, b[63:32]};
    bl  = {32'd0, b[31:0]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
    lo  = {mid[31:0], ll[31:0]};
    return {hi[61:0], lo[63:62]};
  endfunction

  // taylor term divided by (2k)(2k+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] v, input int k);
    logic [63:0] res;
    case (k)
      1:       res = v / 64'd6;
      2:       res = v / 64'd20;
      3:       res = v / 64'd42;
      4:       res = v / 64'd72;
      5:       res = v / 64'd110;
      6:       res = v / 64'd156;
      7:       res = v / 64'd210;
      8:       res = v / 64'd272;
      9:       res = v / 64'd342;
      10:      res = v / 64'd420;
      11:      res = v / 64'd506;
      12:      res = v / 64'd600;
      13:      res = v / 64'd702;
      default: res = v;
    endcase
    return res;
  endfunction

  // sine over the first quarter, q62
  function automatic logic [63:0] sin_quarter(input logic [12:0] r);
    logic [63:0] x, x2, term, sum;
    x    = {51'd0, r} * RAD_PER_UNIT;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 13; k++) begin
      term = taylor_div(mul_q62(term, x2), k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // rounded q1.15 sine of an angle below two full turns
  function automatic trig_t sin_q15(input int a);
    int          am, quad, r;
    logic [63:0] v;
    am = (a >= ANGLE_FULL) ? a - ANGLE_FULL : a;
    if (am >= 3 * ANGLE_QUARTER) begin
      quad = 3;
    end else if (am >= 2 * ANGLE_QUARTER) begin
      quad = 2;
    end else if (am >= ANGLE_QUARTER) begin
      quad = 1;
    end else begin
      quad = 0;
    end
    r = am - quad * ANGLE_QUARTER;
    if ((quad % 2) == 1) begin
      r = ANGLE_QUARTER - r;
    end
    v = (sin_quarter(13'(r)) + HALF_LSB_Q62) >> 47;
    return (quad >= 2) ? -$signed({1'b0, v[15:0]}) : $signed({1'b0, v[15:0]});
  endfunction

  // per-hue table for base angles k*30 deg, optionally a quarter ahead
  function automatic trig_tab_t build_tab(input int k, input int quarter);
    trig_tab_t tab;
    for (int h = 0; h < 256; h++) begin
      tab[h] = sin_q15(ANGLE_THIRTY * k + ANGLE_OFFSET + HUE_STEP * h
                       + quarter * ANGLE_QUARTER);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_K0 = build_tab(0, 0);
  localparam trig_tab_t SIN_K1 = build_tab(1, 0);
  localparam trig_tab_t SIN_K2 = build_tab(2, 0);
  localparam trig_tab_t COS_K0 = build_tab(0, 1);
  localparam trig_tab_t COS_K1 = build_tab(1, 1);
  localparam trig_tab_t COS_K2 = build_tab(2, 1);

endpackage

/* sv/npcg_decode.sv */
`timescale 1ns / 1ps

module npcg_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      tint_i,
  input  logic [7:0]      hue_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [5:0]      color_index_i,
  output logic            valid_o,
  input  logic            ready_i,
  output npcg_pkg::phase_t phase_o
);
  import npcg_pkg::*;

  localparam logic [3:0][6:0] LUMA_WHITE = {7'd100, 7'd100, 7'd75, 7'd50};
  localparam logic [3:0][6:0] LUMA_COLOR = {7'd90, 7'd73, 7'd45, 7'd29};
  localparam logic [3:0][6:0] LUMA_DARK  = {7'd77, 7'd47, 7'd24, 7'd0};

  logic [1:0] row;
  logic [3:0] col;
  logic [1:0] sector;   // base angle / 30 mod 3
  logic [1:0] quad;     // base angle / 90
  trig_t      s0, c0;
  phase_t     phase_d, phase_q;
  logic       valid_q;

  assign row = color_index_i[5:4];
  assign col = color_index_i[3:0];

  always_comb begin
    case (col)
      4'd1:    begin sector = 2'd2; quad = 2'd2; end
      4'd2:    begin sector = 2'd1; quad = 2'd2; end
      4'd3:    begin sector = 2'd0; quad = 2'd2; end
      4'd4:    begin sector = 2'd2; quad = 2'd1; end
      4'd5:    begin sector = 2'd1; quad = 2'd1; end
      4'd6:    begin sector = 2'd0; quad = 2'd1; end
      4'd7:    begin sector = 2'd2; quad = 2'd0; end
      4'd8:    begin sector = 2'd1; quad = 2'd0; end
      4'd10:   begin sector = 2'd2; quad = 2'd3; end
      4'd11:   begin sector = 2'd1; quad = 2'd3; end
      4'd12:   begin sector = 2'd0; quad = 2'd3; end
      default: begin sector = 2'd0; quad = 2'd0; end
    endcase
  end

  always_comb begin
    case (sector)
      2'd0: begin
        s0 = $signed(SIN_K0[hue_i]);
        c0 = $signed(COS_K0[hue_i]);
      end
      2'd1: begin
        s0 = $signed(SIN_K1[hue_i]);
        c0 = $signed(COS_K1[hue_i]);
      end
      default: begin
        s0 = $signed(SIN_K2[hue_i]);
        c0 = $signed(COS_K2[hue_i]);
      end
    endcase
  end

  always_comb begin
    phase_d.tint = 8'd0;
    case (col) inside
      4'd0:         phase_d.luma = LUMA_WHITE[row];
      4'd13:        phase_d.luma = LUMA_DARK[row];
      4'd14, 4'd15: phase_d.luma = 7'd0;
      default: begin
        phase_d.luma = LUMA_COLOR[row];
        phase_d.tint = tint_i;
      end
    endcase
    // quarter turns rotate sin/cos exactly
    case (quad)
      2'd0:    begin phase_d.sin_v = s0;  phase_d.cos_v = c0;  end
      2'd1:    begin phase_d.sin_v = c0;  phase_d.cos_v = -s0; end
      2'd2:    begin phase_d.sin_v = -s0; phase_d.cos_v = -c0; end
      default: begin phase_d.sin_v = -c0; phase_d.cos_v = s0;  end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      phase_q <= phase_d;
    end
  end

  assign valid_o = valid_q;
  assign phase_o = phase_q;

endmodule

/* sv/npcg_chroma.sv */
`timescale 1ns / 1ps

module npcg_chroma (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  npcg_pkg::phase_t phase_i,
  output logic             valid_o,
  input  logic             ready_i,
  output npcg_pkg::level_t level_o
);
  import npcg_pkg::*;

  // stage 2: tint times sin/cos
  logic               v2_q, rdy2;
  logic signed [24:0] ts_d, tc_d, ts_q, tc_q;
  logic [6:0]         luma2_q;

  // stage 3: weighted sums scaled down by 2^15
  logic               v3_q, rdy3;
  logic signed [31:0] ts_w, tc_w, prod_red, prod_blue, sh_red, sh_blue;
  logic signed [35:0] ts_x, tc_x, prod_green, sh_green;
  logic [20:0]        luma_green;
  level_t             level_d, level_q;

  assign ts_d = $signed({1'b0, phase_i.tint}) * phase_i.sin_v;
  assign tc_d = $signed({1'b0, phase_i.tint}) * phase_i.cos_v;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      ts_q    <= ts_d;
      tc_q    <= tc_d;
      luma2_q <= phase_i.luma;
    end
  end

  always_comb begin
    ts_w       = {{7{ts_q[24]}}, ts_q};
    tc_w       = {{7{tc_q[24]}}, tc_q};
    ts_x       = {{11{ts_q[24]}}, ts_q};
    tc_x       = {{11{tc_q[24]}}, tc_q};
    prod_red   = ts_w * 32'sd100;
    prod_blue  = tc_w * (-32'sd100);
    prod_green = tc_x * 36'sd1000 - ts_x * 36'sd2700;
    // arithmetic shifts give the floor of the division by 2^15
    sh_red     = prod_red >>> 15;
    sh_blue    = prod_blue >>> 15;
    sh_green   = prod_green >>> 15;
    luma_green = {14'd0, luma2_q} * 21'd13568;
    level_d.m_red   = $signed({2'b00, luma2_q, 8'h00}) + $signed(sh_red[16:0]);
    level_d.m_blue  = $signed({2'b00, luma2_q, 8'h00}) + $signed(sh_blue[16:0]);
    level_d.m_green = $signed({2'b00, luma_green}) + $signed(sh_green[22:0]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      level_q <= level_d;
    end
  end

  assign valid_o = v3_q;
  assign level_o = level_q;

endmodule

/* sv/npcg_quant.sv */
`timescale 1ns / 1ps

module npcg_quant (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  npcg_pkg::level_t level_i,
  output logic             valid_o,
  input  logic             ready_i,
  output npcg_pkg::rgb_t   rgb_o
);
  import npcg_pkg::*;

  typedef struct packed {
    logic [7:0] quo;
    logic       neg;
    logic       over;
  } quot_t;

  localparam logic signed [16:0] LIMIT_RB = 17'sd25600;     // 256 * 100
  localparam logic signed [22:0] LIMIT_G  = 23'sd1356800;   // 256 * 5300
  localparam logic [15:0]        RECIP_RB = 16'd41944;      // ceil(2^22 / 100)
  localparam logic [20:0]        RECIP_G  = 21'd1620743;    // ceil(2^33 / 5300)

  logic        v4_q, v5_q, rdy4, rdy5;
  logic [30:0] prod_red, prod_blue;
  logic [41:0] prod_green;
  quot_t       qr_d, qg_d, qb_d, qr_q, qg_q, qb_q;
  rgb_t        rgb_d, rgb_q;

  // floor division by reciprocal, exact over the unclamped range
  always_comb begin
    prod_red   = {16'd0, level_i.m_red[14:0]} * {15'd0, RECIP_RB};
    prod_blue  = {16'd0, level_i.m_blue[14:0]} * {15'd0, RECIP_RB};
    prod_green = {21'd0, level_i.m_green[20:0]} * {21'd0, RECIP_G};
    qr_d.quo   = prod_red[29:22];
    qb_d.quo   = prod_blue[29:22];
    qg_d.quo   = prod_green[40:33];
    qr_d.neg   = level_i.m_red[16];
    qb_d.neg   = level_i.m_blue[16];
    qg_d.neg   = level_i.m_green[22];
    qr_d.over  = level_i.m_red >= LIMIT_RB;
    qb_d.over  = level_i.m_blue >= LIMIT_RB;
    qg_d.over  = level_i.m_green >= LIMIT_G;
  end

  function automatic logic [7:0] clamp(input quot_t q);
    logic [7:0] res;
    if (q.neg) begin
      res = 8'd0;
    end else if (q.over) begin
      res = 8'd255;
    end else begin
      res = q.quo;
    end
    return res;
  endfunction

  assign rgb_d.red   = clamp(qr_q);
  assign rgb_d.green = clamp(qg_q);
  assign rgb_d.blue  = clamp(qb_q);

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_q <= valid_i;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && valid_i) begin
      qr_q <= qr_d;
      qg_q <= qg_d;
      qb_q <= qb_d;
    end
    if (rdy5 && v4_q) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = v5_q;
  assign rgb_o   = rgb_q;

endmodule

/* sv/npcg_luma.sv */
`timescale 1ns / 1ps

module npcg_luma (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           grey_mode_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  npcg_pkg::rgb_t rgb_i,
  output logic           valid_o,
  input  logic           ready_i,
  output npcg_pkg::rgb_t rgb_o
);
  import npcg_pkg::*;

  logic        valid_q;
  logic [23:0] wsum;
  rgb_t        rgb_d, rgb_q;

  // q0.16 luma weights, sum 65536
  assign wsum = {16'd0, rgb_i.red} * 24'd19595
              + {16'd0, rgb_i.green} * 24'd38470
              + {16'd0, rgb_i.blue} * 24'd7471;

  assign rgb_d = grey_mode_i ? {wsum[23:16], wsum[23:16], wsum[23:16]} : rgb_i;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

/* sv/nes_palette_color_generator_unit.sv */
`timescale 1ns / 1ps

// palette color generator: 6-bit palette index in, 8-bit red/green/blue out
// input channel: in_valid_i/in_ready_o carry one color_index_i per beat
//   (bits 5:4 brightness row, bits 3:0 hue column)
// output channel: out_valid_o/out_ready_i carry red_o, green_o, blue_o per beat
// config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 tint, 1 hue, 2 grey_mode); other indexes are ignored; write only
//   while the pipe is empty
// throughput: one beat per cycle, sustained, with the receiver taking
// pipeline: six register stages (table lookup, tint products, scaling,
//   reciprocal divide, clamp, luma)
// stall: each stage holds while the next one is full and blocked, bubbles
//   collapse, so the input keeps taking beats until all six stages fill
// reset: rst_ni clears every stage valid and loads tint 128, hue 128,
//   grey mode off; nothing else is stored
module nes_palette_color_generator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input beats
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [5:0] color_index_i,
  // output beats
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);
  import npcg_pkg::*;

  logic [7:0] tint_q, hue_q;
  logic       grey_q;

  // stage handshakes between the units
  logic   dec_valid, dec_ready;
  logic   chr_valid, chr_ready;
  logic   qnt_valid, qnt_ready;
  phase_t dec_phase;
  level_t chr_level;
  rgb_t   qnt_rgb, out_rgb;

  // config registers, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q <= TINT_RESET;
      hue_q  <= HUE_RESET;
      grey_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TINT: tint_q <= cfg_data_i;
        CFG_HUE:  hue_q  <= cfg_data_i;
        CFG_GREY: grey_q <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  // stage 1: luma row, tint gate, hue-indexed sin/cos with quadrant rotation
  npcg_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tint_i        (tint_q),
    .hue_i         (hue_q),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .color_index_i (color_index_i),
    .valid_o       (dec_valid),
    .ready_i       (dec_ready),
    .phase_o       (dec_phase)
  );

  // stages 2-3: tint products, then yiq mix floored by 2^15
  npcg_chroma u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .phase_i (dec_phase),
    .valid_o (chr_valid),
    .ready_i (chr_ready),
    .level_o (chr_level)
  );

  // stages 4-5: divide by 100 / 5300 and clamp to 0..255
  npcg_quant u_quant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chr_valid),
    .ready_o (chr_ready),
    .level_i (chr_level),
    .valid_o (qnt_valid),
    .ready_i (qnt_ready),
    .rgb_o   (qnt_rgb)
  );

  // stage 6: optional luma grey, output register
  npcg_luma u_luma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grey_mode_i (grey_q),
    .valid_i     (qnt_valid),
    .ready_o     (qnt_ready),
    .rgb_i       (qnt_rgb),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .rgb_o       (out_rgb)
  );

  assign red_o   = out_rgb.red;
  assign green_o = out_rgb.green;
  assign blue_o  = out_rgb.blue;

`ifndef SYNTH
  // reset leaves the output empty from the next edge on
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid while in reset");

  // grey mode gives equal channels
  a_grey_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grey_q && out_valid_o |-> (red_o == green_o) && (green_o == blue_o))
    else $error("grey mode beat with unequal channels");

  // only colored columns carry tint, and they use the colored luma row
  a_tint_colored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_valid && (dec_phase.tint != 8'd0) |->
      (dec_phase.luma == 7'd29) || (dec_phase.luma == 7'd45) ||
      (dec_phase.luma == 7'd73) || (dec_phase.luma == 7'd90))
    else $error("tint applied to a grey column");
`endif

endmodule

/* verif/nes_palette_color_generator_unit_test.sv */
`timescale 1ns / 1ps

module nes_palette_color_generator_unit_test;

  // angle bookkeeping in 1/64 degree
  localparam int unsigned TURN_UNITS     = 23040;
  localparam int unsigned QUARTER_UNITS  = 5760;
  localparam int unsigned HUE_ZERO_UNITS = 20608;
  localparam logic [63:0] PI_FRAC62      = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] RAD_PER_UNIT   = PI_FRAC62 / 64'd11520;

  // the one register index that decodes to nothing
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // longest run of cycles with no beat on either side before giving up
  localparam int STALL_LIMIT = 4000;
  // length of each long receiver hold-off
  localparam int HOLD_CYCLES = 150;

  // corner indexes: every row of white and dark columns, black on rows
  // 0, 1, 3, full white on both bright rows, colored columns on all rows
  localparam logic [24*6-1:0] CORNERS = {
    6'h00, 6'h10, 6'h20, 6'h30, 6'h0D, 6'h1D, 6'h2D, 6'h3D,
    6'h0E, 6'h1F, 6'h3F, 6'h01, 6'h3C, 6'h15, 6'h26, 6'h37,
    6'h08, 6'h19, 6'h2A, 6'h3B, 6'h0C, 6'h22, 6'h33, 6'h04
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // predicts the color of every accepted index and matches output beats
  class rgb_scoreboard;
    logic [7:0] tint;
    logic [7:0] hue;
    logic       grey;
    pixel_t     pending_rgb[$];
    int         errors;

    function new();
      tint   = 8'd128;
      hue    = 8'd128;
      grey   = 1'b0;
      errors = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        npcg_pkg::CFG_TINT: tint = data;
        npcg_pkg::CFG_HUE:  hue  = data;
        npcg_pkg::CFG_GREY: grey = data[0];
        default: ;
      endcase
    endfunction

    // exact (a*b) >> 62
    function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    // sine over 0..90 degrees in q62, taylor series to 27th power
    function logic [63:0] quarter_sine(int unsigned r);
      logic [63:0] x, x2, term, sum;
      x    = 64'(r) * RAD_PER_UNIT;
      x2   = frac_mul(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 13; k++) begin
        term = frac_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      return sum;
    endfunction

    // q1.15 sine rounded to nearest
    function longint sine_q15(int unsigned a);
      int unsigned am, quad, r;
      logic [63:0] v;
      am   = a % TURN_UNITS;
      quad = am / QUARTER_UNITS;
      r    = am % QUARTER_UNITS;
      if (quad % 2 == 1) begin
        r = QUARTER_UNITS - r;
      end
      v = (quarter_sine(r) + 64'h0000_4000_0000_0000) >> 47;
      return (quad >= 2) ? -$signed(v) : $signed(v);
    endfunction

    // floor of n/d, clamped to a byte
    function logic [7:0] level(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) begin
        q = q - 1;
      end
      if (q < 0) begin
        q = 0;
      end
      if (q > 255) begin
        q = 255;
      end
      return q[7:0];
    endfunction

    function int unsigned base_degrees(int unsigned col);
      case (col)
        1:       return 240;
        2:       return 210;
        3:       return 180;
        4:       return 150;
        5:       return 120;
        6:       return 90;
        7:       return 60;
        8:       return 30;
        10:      return 330;
        11:      return 300;
        12:      return 270;
        default: return 0;
      endcase
    endfunction

    // luma in hundredths per column class and row
    function longint luma_of(int unsigned col, int unsigned row);
      if (col == 0) begin
        return (row == 0) ? 50 : (row == 1) ? 75 : 100;
      end else if (col == 13) begin
        return (row == 0) ? 0 : (row == 1) ? 24 : (row == 2) ? 47 : 77;
      end else if (col >= 14) begin
        return 0;
      end
      return (row == 0) ? 29 : (row == 1) ? 45 : (row == 2) ? 73 : 90;
    endfunction

    function pixel_t palette_rgb(logic [5:0] idx);
      int unsigned row, col, ang, luma;
      longint      y, t, s, c;
      pixel_t      px;
      row = 32'(idx[5:4]);
      col = 32'(idx[3:0]);
      y   = luma_of(col, row);
      t   = (col >= 1 && col <= 12) ? longint'(tint) : 0;
      ang = (base_degrees(col) * 64 + HUE_ZERO_UNITS + 5 * hue) % TURN_UNITS;
      s   = sine_q15(ang);
      c   = sine_q15((ang + QUARTER_UNITS) % TURN_UNITS);
      px.red   = level(256 * y * 32768 + 100 * t * s, 3276800);
      px.green = level(256 * y * 53 * 32768 - 2700 * t * s + 1000 * t * c, 173670400);
      px.blue  = level(256 * y * 32768 - 100 * t * c, 3276800);
      if (grey) begin
        luma = (19595 * px.red + 38470 * px.green + 7471 * px.blue) >> 16;
        px   = {3{luma[7:0]}};
      end
      return px;
    endfunction

    function void note_index(logic [5:0] idx);
      pending_rgb.push_back(palette_rgb(idx));
    endfunction

    function void mismatch(string field, logic [7:0] exp_v, logic [7:0] act_v);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t want;
      if (pending_rgb.size() == 0) begin
        errors++;
        $display("%0t: beat %0d/%0d/%0d expected none actual one", $time, r, g, b);
        return;
      end
      want = pending_rgb.pop_front();
      if (r !== want.red)   mismatch("red", want.red, r);
      if (g !== want.green) mismatch("green", want.green, g);
      if (b !== want.blue)  mismatch("blue", want.blue, b);
    endfunction

    function int pending();
      return pending_rgb.size();
    endfunction
  endclass

  // every input known from time zero
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_index_i   = '0;
  logic [7:0] cfg_data_i    = '0;
  logic       in_valid_i    = 1'b0;
  logic [5:0] color_index_i = '0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  rgb_scoreboard sb = new();

  // no-idle stretch counters, one per side
  int tx_quiet = 0;
  int rx_quiet = 0;

  nes_palette_color_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .color_index_i (color_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o)
  );

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // idle cycles before the next beat: mostly a random gap, now and then a
  // stretch of back-to-back beats
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // offer one index, hold it until taken; valid stays up when the
  // next beat follows with no gap
  task automatic send_index(input logic [5:0] idx);
    int gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    color_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_index(idx);
  endtask

  // drop valid and let the pipe drain completely
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // write all three registers plus the undecoded index, one per edge
  task automatic program_regs(input logic [7:0] t, input logic [7:0] h,
                              input logic [7:0] g);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= npcg_pkg::CFG_TINT;
    cfg_data_i  <= t;
    @(posedge clk_i);
    sb.apply_reg(npcg_pkg::CFG_TINT, t);
    cfg_index_i <= npcg_pkg::CFG_HUE;
    cfg_data_i  <= h;
    @(posedge clk_i);
    sb.apply_reg(npcg_pkg::CFG_HUE, h);
    cfg_index_i <= npcg_pkg::CFG_GREY;
    cfg_data_i  <= g;
    @(posedge clk_i);
    sb.apply_reg(npcg_pkg::CFG_GREY, g);
    // undecoded index must leave every register alone
    cfg_index_i <= CFG_SPARE;
    cfg_data_i  <= junk;
    @(posedge clk_i);
    sb.apply_reg(CFG_SPARE, junk);
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random ready gaps, plus two long hold-offs so the pipe
  // fills and backs up into the input
  initial begin : drain_side
    int gap;
    int beats;
    beats = 0;
    wait (rst_ni);
    forever begin
      if (beats == 200 || beats == 1000) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = draw_gap(rx_quiet);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_rgb(red_o, green_o, blue_o);
      beats++;
    end
  end

  // watchdog: too long with no beat on either channel
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // stimulus: corners at reset settings, then random phases over
  // extreme and random register settings
  initial begin : stimulus
    logic [7:0] t, h, g;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner indexes with tint 128, hue 128, grey off from reset
    for (int i = 23; i >= 0; i--) begin
      send_index(CORNERS[i*6 +: 6]);
    end
    drain_pipe();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin t = 8'd255; h = 8'd0;   g = 8'h00; end
        1: begin t = 8'd0;   h = 8'd255; g = 8'h01; end
        // grey register keeps only bit 0, upper bits of the write ignored
        2: begin t = 8'd255; h = 8'd255; g = 8'hFE; end
        3: begin t = 8'd255; h = 8'd128; g = 8'hFF; end
        4: begin t = 8'd128; h = 8'd128; g = 8'h00; end
        default: begin t = 8'($urandom); h = 8'($urandom); g = 8'($urandom); end
      endcase
      program_regs(t, h, g);
      for (int n = 0; n < 235; n++) begin
        send_index(6'($urandom_range(0, 63)));
      end
      drain_pipe();
    end

    // wait on to catch any stray output beat
    repeat (12) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
